// ===== src/ti1d_pkg.sv =====
// Shared types, codes and constants of the 1-D table interpolator.
package ti1d_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned MAX_ENTRIES_DEF = 64;
	localparam int unsigned SIZE_W          = 7;
	localparam int unsigned INDEX_W         = 6;

	// Item function codes
	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_COMMIT = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SIZE     = 2'd1;
	localparam logic [1:0] STAT_ORDER    = 2'd2;
	localparam logic [1:0] STAT_NOTVALID = 2'd3;

	// Region codes
	localparam logic [1:0] REG_INSIDE = 2'd0;
	localparam logic [1:0] REG_BELOW  = 2'd1;
	localparam logic [1:0] REG_ABOVE  = 2'd2;

	// Interpolation modes
	localparam logic [1:0] INTERP_LINEAR  = 2'd0;
	localparam logic [1:0] INTERP_NEAREST = 2'd1;
	localparam logic [1:0] INTERP_NEXT    = 2'd2;
	localparam logic [1:0] INTERP_PREV    = 2'd3;

	// Extrapolation modes
	localparam logic [1:0] EXTRAP_CLIP    = 2'd0;
	localparam logic [1:0] EXTRAP_LINEAR  = 2'd1;
	localparam logic [1:0] EXTRAP_SPECIFY = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] CFG_TABLE_SIZE  = 3'd0;
	localparam logic [2:0] CFG_INTERP_MODE = 3'd1;
	localparam logic [2:0] CFG_EXTRAP_MODE = 3'd2;
	localparam logic [2:0] CFG_LOWER_VALUE = 3'd3;
	localparam logic [2:0] CFG_UPPER_VALUE = 3'd4;

	// Request to the linear interpolation unit
	typedef struct packed {
		logic                     start;
		logic signed [DATA_W-1:0] xq;
		logic signed [DATA_W-1:0] x1;
		logic signed [DATA_W-1:0] x2;
		logic signed [DATA_W-1:0] y1;
		logic signed [DATA_W-1:0] y2;
	} lin_req_t;

	// Response of the linear interpolation unit
	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] value;
	} lin_rsp_t;

endpackage

// ===== src/ti1d_mem.sv =====
// Breakpoint memory: x and y arrays, one write port, one shared read address.
module ti1d_mem
	import ti1d_pkg::*;
#(
	parameter int unsigned DEPTH  = MAX_ENTRIES_DEF,
	parameter int unsigned ADDR_W = $clog2(MAX_ENTRIES_DEF)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [DATA_W-1:0] wx,
	input  logic signed [DATA_W-1:0] wy,
	input  logic [ADDR_W-1:0]        raddr,
	output logic signed [DATA_W-1:0] rx,
	output logic signed [DATA_W-1:0] ry
);

	logic signed [DATA_W-1:0] x_mem [DEPTH];
	logic signed [DATA_W-1:0] y_mem [DEPTH];

	// Write the pair
	always_ff @(posedge clk) begin
		if (we) begin
			x_mem[waddr] <= wx;
			y_mem[waddr] <= wy;
		end
	end

	// Registered read: the data appears in the cycle after the address
	always_ff @(posedge clk) begin
		rx <= x_mem[raddr];
		ry <= y_mem[raddr];
	end

endmodule

// ===== src/ti1d_lin.sv =====
// Linear interpolation unit: exact product, bit-serial restoring divide, saturate.
module ti1d_lin
	import ti1d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  lin_req_t req,
	output lin_rsp_t rsp
);

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_MUL  = 4'b0010,
		L_DIV  = 4'b0100,
		L_OUT  = 4'b1000
	} lin_state_t;

	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned CNT_W  = $clog2(PROD_W);
	localparam int unsigned QUO_W  = 40;
	localparam int unsigned SUM_W  = QUO_W + 3;

	lin_state_t              state_q;
	logic [DATA_W-1:0]       a_q;
	logic [DATA_W-1:0]       b_q;
	logic [DATA_W-1:0]       dx_q;
	logic                    neg_q;
	logic signed [DATA_W-1:0] y1_q;
	logic [PROD_W-1:0]       dvd_q;
	logic [DATA_W-1:0]       rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic                    sat_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [DATA_W-1:0] value_q;
	logic                    done_q;

	logic signed [DATA_W:0]  num;
	logic signed [DATA_W:0]  dy;
	logic signed [DATA_W:0]  dxw;
	logic [DATA_W:0]         num_abs;
	logic [DATA_W:0]         dy_abs;
	logic [PROD_W-1:0]       prod;
	logic [DATA_W:0]         rem_sh;
	logic [DATA_W:0]         rem_sub;
	logic                    ge;
	logic [QUO_W:0]          mag;
	logic signed [SUM_W-1:0] sum;
	logic signed [DATA_W-1:0] sat_val;

	// Differences and magnitudes of the operands
	always_comb begin
		num     = {req.xq[DATA_W-1], req.xq} - {req.x1[DATA_W-1], req.x1};
		dy      = {req.y2[DATA_W-1], req.y2} - {req.y1[DATA_W-1], req.y1};
		dxw     = {req.x2[DATA_W-1], req.x2} - {req.x1[DATA_W-1], req.x1};
		num_abs = num[DATA_W] ? -num : num;
		dy_abs  = dy[DATA_W] ? -dy : dy;
	end

	assign prod = a_q * b_q;

	// One restoring divide step
	always_comb begin
		rem_sh  = {rem_q, dvd_q[PROD_W-1]};
		ge      = rem_sh >= {1'b0, dx_q};
		rem_sub = rem_sh - {1'b0, dx_q};
	end

	// Apply sign, add base and saturate
	always_comb begin
		mag = sat_q ? {1'b1, {QUO_W{1'b0}}} : {1'b0, quo_q};
		sum = SUM_W'(y1_q) + (neg_q ? -SUM_W'(mag) : SUM_W'(mag));
		if (sum > SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
			sat_val = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum < -SUM_W'(signed'({1'b0, 1'b1, {(DATA_W-1){1'b0}}}))) begin
			sat_val = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat_val = sum[DATA_W-1:0];
		end
	end

	// Sequence the multiply and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (req.start) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					state_q <= L_DIV;
				end
				L_DIV: begin
					if (cnt_q == '0) begin
						state_q <= L_OUT;
					end
				end
				L_OUT: begin
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				a_q   <= num_abs[DATA_W-1:0];
				b_q   <= dy_abs[DATA_W-1:0];
				dx_q  <= dxw[DATA_W-1:0];
				neg_q <= num[DATA_W] ^ dy[DATA_W];
				y1_q  <= req.y1;
			end
			L_MUL: begin
				dvd_q <= prod;
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				cnt_q <= CNT_W'(PROD_W - 1);
			end
			L_DIV: begin
				dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
				rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				if (ge && (cnt_q >= CNT_W'(QUO_W))) begin
					sat_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			L_OUT: begin
				value_q <= sat_val;
			end
			default: begin
			end
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

// ===== src/table_interp_1d.sv =====
// Top level of the 1-D breakpoint table interpolator.
// Usage:
//   Input channel (in_valid/in_stall) carries func, entry_index, x_value,
//   y_value. Output channel (out_valid/out_stall) returns result_value,
//   status and region: one result transaction per input transaction.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   table_size, interp_mode, extrap_mode, lower_value, upper_value; write it
//   only while the block is idle.
// Sequencing (one item at a time):
//   write entry and other short items: straight to the result register.
//   commit: a scan of the table, one memory read per cycle.
//   lookup: reads of the end breakpoints, a binary search with a read and
//   a compare per step, the segment read, then the linear unit, dominated
//   by its one-bit-per-cycle 64-step divide.
// Reset clears the valid flag, the last result, the configuration and the
// sequencer state; memory contents are undefined until written. A stalled
// result is held in the output register; the next item is accepted
// meanwhile and finishes once the register frees up.
module table_interp_1d
	import ti1d_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic signed [DATA_W-1:0] x_value,
	input  logic signed [DATA_W-1:0] y_value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status,
	output logic [1:0]               region,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = (AW >= SIZE_W) ? AW + 1 : SIZE_W;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CSCAN = 11'b00000000010,
		ST_RD0   = 11'b00000000100,
		ST_RDN   = 11'b00000001000,
		ST_BSRD  = 11'b00000010000,
		ST_BSCMP = 11'b00000100000,
		ST_SEGA  = 11'b00001000000,
		ST_SEGB  = 11'b00010000000,
		ST_SEGC  = 11'b00100000000,
		ST_LIN   = 11'b01000000000,
		ST_FIN   = 11'b10000000000
	} state_t;

	state_t                   state_q;
	logic [SIZE_W-1:0]        table_size_q;
	logic [1:0]               interp_q;
	logic [1:0]               extrap_q;
	logic signed [DATA_W-1:0] lower_q;
	logic signed [DATA_W-1:0] upper_q;
	logic                     table_ok_q;
	logic signed [DATA_W-1:0] last_q;

	logic signed [DATA_W-1:0] xq_q;
	logic signed [DATA_W-1:0] x0_q;
	logic signed [DATA_W-1:0] y0_q;
	logic signed [DATA_W-1:0] xa_q;
	logic signed [DATA_W-1:0] ya_q;
	logic signed [DATA_W-1:0] prev_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            lo_q;
	logic [CW-1:0]            hi_q;
	logic [CW-1:0]            mid_q;
	logic                     rd_vld_s1;
	logic [CW-1:0]            rd_idx_s1;
	logic                     bad_q;
	logic                     force_lin_q;
	logic signed [DATA_W-1:0] res_q;
	logic [1:0]               stat_q;
	logic [1:0]               region_q;
	logic                     upd_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_res_q;
	logic [1:0]               out_stat_q;
	logic [1:0]               out_region_q;

	logic                     in_acc;
	logic                     mem_we;
	logic [AW-1:0]            raddr;
	logic signed [DATA_W-1:0] rx;
	logic signed [DATA_W-1:0] ry;
	logic [CW-1:0]            n_w;
	logic [CW-1:0]            n_m1;
	logic [CW:0]              mid_sum;
	logic [CW-1:0]            nlo;
	logic [CW-1:0]            nhi;
	logic                     below;
	logic                     above;
	logic                     bad_nx;
	logic signed [DATA_W:0]   d_lo;
	logic signed [DATA_W:0]   d_hi;
	logic                     out_free;
	lin_req_t                 lin_req;
	lin_rsp_t                 lin_rsp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign mem_we    = in_acc && (func == FUNC_WRITE) &&
	                   (CW'(entry_index) < CW'(MAX_ENTRIES));
	assign n_w       = CW'(table_size_q);
	assign n_m1      = n_w - 1'b1;

	// Binary search step and range checks
	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		if (xq_q <= rx) begin
			nlo = lo_q;
			nhi = mid_q;
		end else begin
			nlo = mid_q + 1'b1;
			nhi = hi_q;
		end
		below  = xq_q < x0_q;
		above  = xq_q > rx;
		bad_nx = bad_q || (rd_vld_s1 && (rd_idx_s1 != '0) && (rx <= prev_q));
		d_lo   = {xq_q[DATA_W-1], xq_q} - {xa_q[DATA_W-1], xa_q};
		d_hi   = {rx[DATA_W-1], rx} - {xq_q[DATA_W-1], xq_q};
	end

	// Select the read address
	always_comb begin
		case (state_q)
			ST_CSCAN: raddr = cnt_q[AW-1:0];
			ST_RD0:   raddr = n_m1[AW-1:0];
			ST_BSRD:  raddr = mid_sum[AW:1];
			ST_SEGA:  raddr = AW'(lo_q - 1'b1);
			ST_SEGB:  raddr = lo_q[AW-1:0];
			default:  raddr = '0;
		endcase
	end

	// Start the linear unit on the segment
	always_comb begin
		lin_req.start = (state_q == ST_SEGC) && (force_lin_q || (interp_q == INTERP_LINEAR));
		lin_req.xq    = xq_q;
		lin_req.x1    = xa_q;
		lin_req.x2    = rx;
		lin_req.y1    = ya_q;
		lin_req.y2    = ry;
	end

	ti1d_mem #(
		.DEPTH  (MAX_ENTRIES),
		.ADDR_W (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(entry_index)),
		.wx    (x_value),
		.wy    (y_value),
		.raddr (raddr),
		.rx    (rx),
		.ry    (ry)
	);

	ti1d_lin u_lin (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lin_req),
		.rsp    (lin_rsp)
	);

	// Control: sequencer, valid flag, configuration, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			table_size_q <= '0;
			interp_q     <= INTERP_LINEAR;
			extrap_q     <= EXTRAP_CLIP;
			lower_q      <= '0;
			upper_q      <= '0;
			table_ok_q   <= 1'b0;
			last_q       <= '0;
			out_valid_q  <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TABLE_SIZE: begin
						table_size_q <= cfg_data[SIZE_W-1:0];
						table_ok_q   <= 1'b0;
					end
					CFG_INTERP_MODE: interp_q <= cfg_data[1:0];
					CFG_EXTRAP_MODE: extrap_q <= cfg_data[1:0];
					CFG_LOWER_VALUE: lower_q  <= cfg_data;
					CFG_UPPER_VALUE: upper_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			// Drop a taken result
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			rd_vld_s1 <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							FUNC_WRITE: begin
								table_ok_q <= 1'b0;
								state_q    <= ST_FIN;
							end
							FUNC_COMMIT: begin
								if ((n_w < CW'(2)) || (n_w > CW'(MAX_ENTRIES))) begin
									table_ok_q <= 1'b0;
									state_q    <= ST_FIN;
								end else begin
									state_q <= ST_CSCAN;
								end
							end
							FUNC_LOOKUP: begin
								state_q <= table_ok_q ? ST_RD0 : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_CSCAN: begin
					rd_vld_s1 <= (cnt_q < n_w);
					if (rd_vld_s1 && (rd_idx_s1 == n_m1)) begin
						table_ok_q <= !bad_nx;
						state_q    <= ST_FIN;
						rd_vld_s1  <= 1'b0;
					end
				end
				ST_RD0: begin
					state_q <= ST_RDN;
				end
				ST_RDN: begin
					if (below || above) begin
						state_q <= (extrap_q == EXTRAP_LINEAR) ? ST_SEGA : ST_FIN;
					end else begin
						state_q <= (CW'(1) < n_m1) ? ST_BSRD : ST_SEGA;
					end
				end
				ST_BSRD: begin
					state_q <= ST_BSCMP;
				end
				ST_BSCMP: begin
					state_q <= (nlo < nhi) ? ST_BSRD : ST_SEGA;
				end
				ST_SEGA: begin
					state_q <= ST_SEGB;
				end
				ST_SEGB: begin
					state_q <= ST_SEGC;
				end
				ST_SEGC: begin
					state_q <= lin_req.start ? ST_LIN : ST_FIN;
				end
				ST_LIN: begin
					if (lin_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (upd_q) begin
							last_q <= res_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				xq_q     <= x_value;
				res_q    <= last_q;
				stat_q   <= STAT_OK;
				region_q <= REG_INSIDE;
				upd_q    <= 1'b0;
				cnt_q    <= '0;
				bad_q    <= 1'b0;
				if (func == FUNC_COMMIT &&
				    ((n_w < CW'(2)) || (n_w > CW'(MAX_ENTRIES)))) begin
					stat_q <= STAT_SIZE;
				end
				if (func == FUNC_LOOKUP && !table_ok_q) begin
					stat_q <= STAT_NOTVALID;
				end
			end
			ST_CSCAN: begin
				if (cnt_q < n_w) begin
					cnt_q <= cnt_q + 1'b1;
				end
				rd_idx_s1 <= cnt_q;
				bad_q     <= bad_nx;
				if (rd_vld_s1) begin
					prev_q <= rx;
				end
				if (rd_vld_s1 && (rd_idx_s1 == n_m1)) begin
					stat_q <= bad_nx ? STAT_ORDER : STAT_OK;
				end
			end
			ST_RD0: begin
				x0_q <= rx;
				y0_q <= ry;
			end
			ST_RDN: begin
				force_lin_q <= 1'b0;
				lo_q        <= CW'(1);
				hi_q        <= n_m1;
				if (below || above) begin
					region_q <= below ? REG_BELOW : REG_ABOVE;
					upd_q    <= 1'b1;
					case (extrap_q)
						EXTRAP_CLIP:    res_q <= below ? y0_q : ry;
						EXTRAP_LINEAR: begin
							force_lin_q <= 1'b1;
							lo_q        <= below ? CW'(1) : n_m1;
						end
						EXTRAP_SPECIFY: res_q <= below ? lower_q : upper_q;
						default:        upd_q <= 1'b0;
					endcase
				end
			end
			ST_BSRD: begin
				mid_q <= mid_sum[CW:1];
			end
			ST_BSCMP: begin
				lo_q <= nlo;
				hi_q <= nhi;
			end
			ST_SEGB: begin
				xa_q <= rx;
				ya_q <= ry;
			end
			ST_SEGC: begin
				upd_q <= 1'b1;
				case (interp_q)
					INTERP_NEAREST: res_q <= (d_lo <= d_hi) ? ya_q : ry;
					INTERP_NEXT:    res_q <= ry;
					INTERP_PREV:    res_q <= ya_q;
					default:        res_q <= ya_q;
				endcase
			end
			ST_LIN: begin
				if (lin_rsp.done) begin
					res_q <= lin_rsp.value;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_res_q    <= res_q;
					out_stat_q   <= stat_q;
					out_region_q <= region_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_res_q;
	assign status       = out_stat_q;
	assign region       = out_region_q;

`ifndef NO_ASSERTIONS
	// The linear unit answers only while the sequencer waits on it
	a_lin_done: assert property (@(posedge clk) disable iff (!arst_n)
		lin_rsp.done |-> state_q == ST_LIN)
		else $error("linear unit result outside its wait state");

	// A memory write happens only when an item is taken
	a_mem_we: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (in_valid && state_q == ST_IDLE))
		else $error("memory write without an accepted item");

	// A not-valid status never carries an out-of-table region
	a_stat_region: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_NOTVALID) |-> region == REG_INSIDE)
		else $error("region reported on an invalid table");

	// A lookup only starts on a valid table
	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD0) |-> table_ok_q)
		else $error("lookup running on an invalid table");
`endif

endmodule
